// ===== rtl/tpq_pkg.sv =====
// Package with shared constants, register map and controller interface types.
package tpq_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int POS_W = 12;
	localparam int PRESSURE_W = 28;
	localparam int OUT_DATA_W = ((POS_W + POS_W + PRESSURE_W + 7) / 8) * 8;
	localparam int ROUND_ADD = 2047;
	localparam int ROUND_SHIFT = 12;

	localparam logic [15:0] PLATE_OHMS_RESET = 16'd400;
	localparam logic [31:0] MAX_PRESSURE_RESET = 32'hFFFF_FFFF;
	localparam logic [15:0] PEN_UP_TICKS_RESET = 16'd10;
	localparam logic [PRESSURE_W-1:0] PRESSURE_MAX = {PRESSURE_W{1'b1}};

	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_PLATE_OHMS = 2'd0;
	localparam logic [1:0] REG_MAX_PRESSURE = 2'd1;
	localparam logic [1:0] REG_PEN_UP_TICKS = 2'd2;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic div_step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic nonzero;
		logic div_last;
		logic emit;
		logic out_free;
	} ctrl_status_t;

endpackage

// ===== rtl/tpq_ctrl.sv =====
// Controller state machine that sequences decode, multiply, divide and commit.
module tpq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_fire,
	output logic                  in_ready,
	input  tpq_pkg::ctrl_status_t st,
	output tpq_pkg::ctrl_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_MUL2   = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_FIN    = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (st.is_tick) begin
					state_d = S_FIN;
				end else if (!st.nonzero) begin
					state_d = S_IDLE;
				end else begin
					cmd.mul1 = 1'b1;
					state_d = S_MUL2;
				end
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!st.emit || st.out_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/tpq_datapath.sv =====
// Datapath with sample registers, multipliers, restoring divider, touch state and result register.
module tpq_datapath #(
	parameter int SAMPLE_BITS = tpq_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tpq_pkg::ctrl_cmd_t                  cmd,
	output tpq_pkg::ctrl_status_t               st,
	input  logic                                in_command,
	input  logic [SAMPLE_BITS-1:0]              in_x,
	input  logic [SAMPLE_BITS-1:0]              in_y,
	input  logic [SAMPLE_BITS-1:0]              in_z1,
	input  logic [SAMPLE_BITS-1:0]              in_z2,
	input  logic [15:0]                         plate_ohms,
	input  logic [31:0]                         max_pressure,
	input  logic [15:0]                         pen_up_ticks,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                out_touching,
	output logic [tpq_pkg::POS_W-1:0]           out_x,
	output logic [tpq_pkg::POS_W-1:0]           out_y,
	output logic [tpq_pkg::PRESSURE_W-1:0]      out_pressure
);

	localparam int SB = SAMPLE_BITS;
	localparam int PROD_W = 2 * SB + 16;
	localparam int RES_W = PROD_W + 1 - tpq_pkg::ROUND_SHIFT;
	localparam int EXT_W = (RES_W > tpq_pkg::PRESSURE_W) ? RES_W : tpq_pkg::PRESSURE_W;
	localparam int XE_W = (SB > tpq_pkg::POS_W) ? SB : tpq_pkg::POS_W;
	localparam int CNT_W = $clog2(PROD_W);
	localparam int PW = tpq_pkg::PRESSURE_W;
	localparam int QW = tpq_pkg::POS_W;

	logic              cmd_q;
	logic [SB-1:0]     x_q;
	logic [SB-1:0]     y_q;
	logic [SB-1:0]     z1_q;
	logic [SB-1:0]     diff_q;
	logic [2*SB-1:0]   p1_q;
	logic [PROD_W-1:0] quo_q;
	logic [SB-1:0]     rem_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [QW-1:0]     last_x_q;
	logic [QW-1:0]     last_y_q;
	logic [PW-1:0]     last_p_q;
	logic [15:0]       cd_q;

	logic              out_valid_q;
	logic              out_touch_q;
	logic [QW-1:0]     out_x_q;
	logic [QW-1:0]     out_y_q;
	logic [PW-1:0]     out_p_q;

	logic [SB:0]       div_sh;
	logic [SB:0]       div_z1;
	logic              div_ge;
	logic [SB:0]       div_rem;
	logic [PROD_W:0]   round_sum;
	logic [RES_W-1:0]  res_full;
	logic [EXT_W-1:0]  res_ext;
	logic [PW-1:0]     res_sat;
	logic              sample_ok;
	logic [XE_W-1:0]   x_ext;
	logic [XE_W-1:0]   y_ext;

	assign div_sh  = {rem_q, quo_q[PROD_W-1]};
	assign div_z1  = {1'b0, z1_q};
	assign div_ge  = (div_sh >= div_z1);
	assign div_rem = div_ge ? (div_sh - div_z1) : div_sh;

	assign round_sum = {1'b0, quo_q} + (PROD_W + 1)'(tpq_pkg::ROUND_ADD);
	assign res_full  = round_sum[PROD_W:tpq_pkg::ROUND_SHIFT];
	assign res_ext   = EXT_W'(res_full);
	assign res_sat   = (res_ext > EXT_W'(tpq_pkg::PRESSURE_MAX)) ?
		tpq_pkg::PRESSURE_MAX : res_ext[PW-1:0];
	assign sample_ok = ({{(32 - PW){1'b0}}, res_sat} <= max_pressure);

	assign x_ext = XE_W'(x_q);
	assign y_ext = XE_W'(y_q);

	assign st.is_tick  = (cmd_q == tpq_pkg::CMD_TICK);
	assign st.nonzero  = (x_q != '0) && (z1_q != '0);
	assign st.div_last = (cnt_q == '0);
	assign st.emit     = st.is_tick ? (cd_q == 16'd1) : (sample_ok && (cd_q != 16'd0));
	assign st.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= in_command;
			x_q    <= in_x;
			y_q    <= in_y;
			z1_q   <= in_z1;
			diff_q <= (in_z2 > in_z1) ? (in_z2 - in_z1) : '0;
		end
		if (cmd.mul1) begin
			p1_q <= (2 * SB)'(diff_q) * (2 * SB)'(x_q);
		end
		if (cmd.mul2) begin
			quo_q <= PROD_W'(p1_q) * PROD_W'(plate_ohms);
			rem_q <= '0;
			cnt_q <= CNT_W'(PROD_W - 1);
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[PROD_W-2:0], div_ge};
			rem_q <= div_rem[SB-1:0];
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
			last_p_q <= '0;
			cd_q     <= '0;
		end else if (cmd.commit) begin
			if (st.is_tick) begin
				if (cd_q != 16'd0) begin
					cd_q <= cd_q - 16'd1;
				end
			end else if (sample_ok) begin
				last_x_q <= x_ext[QW-1:0];
				last_y_q <= y_ext[QW-1:0];
				last_p_q <= res_sat;
				cd_q     <= (pen_up_ticks == 16'd0) ? 16'd1 : pen_up_ticks;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit && st.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && st.emit) begin
			out_touch_q <= !st.is_tick;
			out_x_q     <= st.is_tick ? '0 : last_x_q;
			out_y_q     <= st.is_tick ? '0 : last_y_q;
			out_p_q     <= st.is_tick ? '0 : last_p_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_touching = out_touch_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign out_pressure = out_p_q;

endmodule

// ===== rtl/touch_pressure_qualifier_top.sv =====
// Top level of the touch pressure qualifier with stream channels and register port.
//
// Input items arrive on the s_ channel: s_tuser selects a conversion sample (0) or a
// time tick (1), s_tdata carries x, y, z1 and z2. Result items leave on the m_ channel:
// m_tuser is set for a touch report and clear for a pen-up report.
// A sample with nonzero x and z1 goes through multiply steps and a restoring divider
// that produces one quotient bit per cycle over 2*SAMPLE_BITS+16 bits; the block takes
// a new item only once it is through with the current one, whether a sample or a tick.
// A result shows on m_tvalid the cycle after its item finishes, held in an output
// register; the next item is accepted while it waits.
// If the receiver stalls and a second result is ready, the block holds it and stops
// accepting input until the output register frees.
// Reset clears the stored sample, stops the pen-up countdown and loads the register
// defaults (plate 400 ohms, maximum pressure all ones, 10 pen-up ticks).
// Registers are written through the APB port at byte addresses 0, 4 and 8.
module touch_pressure_qualifier_top #(
	parameter int SAMPLE_BITS = tpq_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// x_position, y_position, z1_value, z2_value from bit 0 up, zero padded.
	input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	// command.
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// report_x, report_y, report_pressure from bit 0 up, zero padded.
	output logic [tpq_pkg::OUT_DATA_W-1:0]    m_tdata,
	// touching.
	output logic                              m_tuser,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tpq_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int SB = SAMPLE_BITS;
	localparam int PW = tpq_pkg::PRESSURE_W;
	localparam int QW = tpq_pkg::POS_W;
	localparam int PAD_W = tpq_pkg::OUT_DATA_W - 2 * QW - PW;

	logic [15:0] plate_q;
	logic [31:0] maxp_q;
	logic [15:0] penup_q;
	logic        cfg_wr;
	logic [1:0]  reg_idx;

	tpq_pkg::ctrl_cmd_t    cmd;
	tpq_pkg::ctrl_status_t st;

	logic          in_fire;
	logic [QW-1:0] rep_x;
	logic [QW-1:0] rep_y;
	logic [PW-1:0] rep_p;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plate_q <= tpq_pkg::PLATE_OHMS_RESET;
			maxp_q  <= tpq_pkg::MAX_PRESSURE_RESET;
			penup_q <= tpq_pkg::PEN_UP_TICKS_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				tpq_pkg::REG_PLATE_OHMS:   plate_q <= pwdata[15:0];
				tpq_pkg::REG_MAX_PRESSURE: maxp_q  <= pwdata;
				tpq_pkg::REG_PEN_UP_TICKS: penup_q <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			tpq_pkg::REG_PLATE_OHMS:   prdata = {16'd0, plate_q};
			tpq_pkg::REG_MAX_PRESSURE: prdata = maxp_q;
			tpq_pkg::REG_PEN_UP_TICKS: prdata = {16'd0, penup_q};
			default:                   prdata = 32'd0;
		endcase
	end

	assign in_fire = s_tvalid && s_tready;

	tpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	tpq_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.in_command   (s_tuser),
		.in_x         (s_tdata[SB-1:0]),
		.in_y         (s_tdata[2*SB-1:SB]),
		.in_z1        (s_tdata[3*SB-1:2*SB]),
		.in_z2        (s_tdata[4*SB-1:3*SB]),
		.plate_ohms   (plate_q),
		.max_pressure (maxp_q),
		.pen_up_ticks (penup_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_touching (m_tuser),
		.out_x        (rep_x),
		.out_y        (rep_y),
		.out_pressure (rep_p)
	);

	assign m_tdata = {{PAD_W{1'b0}}, rep_p, rep_y, rep_x};

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("input accepted while an item is still in work");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && st.emit) |=> m_tvalid)
		else $error("committed result did not reach the output");

	a_penup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (rep_p == '0 && rep_x == '0 && rep_y == '0))
		else $error("pen-up report carries nonzero fields");
`endif

endmodule
